// ===== hdl/ramn_pkg.sv =====
// ----------------------------------------------------------------------------
// ramn_pkg
// Shared widths, codes and controller/datapath interface types for the
// mutual exclusion node.
// ----------------------------------------------------------------------------
`default_nettype none

package ramn_pkg;

    localparam int NODE_COUNT = 16;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT);
    localparam int STAMP_W    = 48;
    localparam int PEER_W     = 5;
    localparam int OP_W       = 3;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_PEER_REQ    = 3'd0,
        OP_PEER_REPLY  = 3'd1,
        OP_LOCAL_REQ   = 3'd2,
        OP_RELEASE     = 3'd3,
        OP_TIMEOUT     = 3'd4,
        OP_FAIL_TOGGLE = 3'd5
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_REPLY   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_IDLE    = 2'd0,
        STATUS_WAITING = 2'd1,
        STATUS_IN_CS   = 2'd2,
        STATUS_FAILED  = 2'd3
    } status_t;

    typedef struct packed {
        logic latch;
        logic eval;
        logic emit_msg;
        logic emit_none;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic send_empty;
        logic cur_bit;
        logic rest_empty;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/ramn_ctrl.sv =====
// ----------------------------------------------------------------------------
// ramn_ctrl
// Sequencer: takes one event word, evaluates it, then walks the peer map
// and hands each result word to the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ramn_ctrl (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire ramn_pkg::dp_status_t dp_status,
    output ramn_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_NONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (dp_status.send_empty) begin
                    state_next = ST_NONE;
                end else if (dp_status.cur_bit) begin
                    if (dp_status.out_free) begin
                        cmd.emit_msg = 1'b1;
                        if (dp_status.rest_empty) begin
                            state_next = ST_IDLE;
                        end else begin
                            cmd.advance = 1'b1;
                        end
                    end
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_NONE: begin
                if (dp_status.out_free) begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ramn_datapath.sv =====
// ----------------------------------------------------------------------------
// ramn_datapath
// Node state, Lamport clock, event evaluation, outgoing peer map and the
// result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ramn_datapath (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [ramn_pkg::PEER_W-1:0]        cfg_data,
    input  wire  [ramn_pkg::OP_W-1:0]          s_operation,
    input  wire  [ramn_pkg::PEER_W-1:0]        s_sender_peer,
    input  wire  [ramn_pkg::STAMP_W-1:0]       s_in_stamp,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [ramn_pkg::KIND_W-1:0]        m_msg_kind,
    output logic [ramn_pkg::PEER_W-1:0]        m_dest_peer,
    output logic [ramn_pkg::STAMP_W-1:0]       m_out_stamp,
    output logic [ramn_pkg::STATUS_W-1:0]      m_node_status,
    output logic                               m_granted,
    output logic                               m_last_result,
    input  wire ramn_pkg::ctrl_cmd_t           cmd,
    output ramn_pkg::dp_status_t               dp_status
);

    localparam int N  = ramn_pkg::NODE_COUNT;
    localparam int SW = ramn_pkg::STAMP_W;
    localparam int PW = ramn_pkg::PEER_W;
    localparam int IW = ramn_pkg::IDX_W;
    localparam int CW = ramn_pkg::CNT_W;

    logic [PW-1:0]   own_id_reg;
    logic [SW-1:0]   clock_reg,     clock_next;
    logic [SW-1:0]   own_stamp_reg, own_stamp_next;
    logic [CW-1:0]   pending_reg,   pending_next;
    logic            wants_reg,     wants_next;
    logic            in_cs_reg,     in_cs_next;
    logic            failed_reg,    failed_next;
    logic [N-1:0]    deferred_reg,  deferred_next;
    logic [N-1:0]    send_map_reg,  send_map_next;
    ramn_pkg::kind_t kind_reg,      kind_next;
    logic            grant_reg,     grant_next;
    logic [IW-1:0]   idx_reg,       idx_next;

    ramn_pkg::op_t   op_reg;
    logic [PW-1:0]   snd_reg;
    logic [SW-1:0]   stamp_reg;

    logic            m_valid_reg;
    ramn_pkg::kind_t m_kind_reg;
    logic [PW-1:0]   m_dest_reg;
    logic [SW-1:0]   m_stamp_reg;
    ramn_pkg::status_t m_status_reg;
    logic            m_grant_reg;
    logic            m_last_reg;

    logic [N-1:0]    peer_hot;
    logic [N-1:0]    own_hot;
    logic [N-1:0]    sel_hot;
    logic            sender_ok;
    logic            earlier;
    logic            merge_op;
    logic [SW-1:0]   merged;
    logic [SW-1:0]   base;
    logic [SW-1:0]   ticked;
    logic            out_free;
    logic            load_out;
    ramn_pkg::status_t status_now;

    assign cfg_ready = aresetn;

    always_comb begin
        for (int j = 0; j < N; j++) begin
            peer_hot[j] = (int'(snd_reg) == j + 1);
            own_hot[j]  = (int'(own_id_reg) == j + 1);
            sel_hot[j]  = (idx_reg == IW'(j));
        end
    end

    assign sender_ok = (snd_reg != '0) && (int'(snd_reg) <= N) && (snd_reg != own_id_reg);
    assign earlier   = (own_stamp_reg < stamp_reg) ||
                       ((own_stamp_reg == stamp_reg) && (own_id_reg < snd_reg));
    assign merge_op  = (op_reg == ramn_pkg::OP_PEER_REQ) || (op_reg == ramn_pkg::OP_PEER_REPLY);
    assign merged    = (stamp_reg > clock_reg) ? stamp_reg : clock_reg;
    assign base      = merge_op ? merged : clock_reg;
    assign ticked    = (base == ramn_pkg::STAMP_MAX) ? base : base + SW'(1);

    always_comb begin
        if (failed_reg) begin
            status_now = ramn_pkg::STATUS_FAILED;
        end else if (in_cs_reg) begin
            status_now = ramn_pkg::STATUS_IN_CS;
        end else if (wants_reg) begin
            status_now = ramn_pkg::STATUS_WAITING;
        end else begin
            status_now = ramn_pkg::STATUS_IDLE;
        end
    end

    always_comb begin
        clock_next     = clock_reg;
        own_stamp_next = own_stamp_reg;
        pending_next   = pending_reg;
        wants_next     = wants_reg;
        in_cs_next     = in_cs_reg;
        failed_next    = failed_reg;
        deferred_next  = deferred_reg;
        send_map_next  = send_map_reg;
        kind_next      = kind_reg;
        grant_next     = grant_reg;
        idx_next       = idx_reg;

        if (cmd.eval) begin
            send_map_next = '0;
            kind_next     = ramn_pkg::KIND_REPLY;
            grant_next    = 1'b0;
            idx_next      = '0;
            case (op_reg)
                ramn_pkg::OP_PEER_REQ: begin
                    if (!failed_reg && sender_ok) begin
                        clock_next = ticked;
                        if (wants_reg && earlier) begin
                            deferred_next = deferred_reg | peer_hot;
                        end else begin
                            send_map_next = peer_hot;
                        end
                    end
                end
                ramn_pkg::OP_PEER_REPLY: begin
                    if (!failed_reg && sender_ok) begin
                        clock_next = ticked;
                        if (wants_reg && (pending_reg != '0)) begin
                            pending_next = pending_reg - CW'(1);
                            if (pending_reg == CW'(1)) begin
                                in_cs_next = 1'b1;
                                grant_next = 1'b1;
                            end
                        end
                    end
                end
                ramn_pkg::OP_LOCAL_REQ: begin
                    if (!failed_reg && !wants_reg && !in_cs_reg) begin
                        clock_next     = ticked;
                        own_stamp_next = ticked;
                        wants_next     = 1'b1;
                        pending_next   = CW'(N - 1);
                        send_map_next  = ~own_hot;
                        kind_next      = ramn_pkg::KIND_REQUEST;
                    end
                end
                ramn_pkg::OP_RELEASE: begin
                    if (!failed_reg && in_cs_reg) begin
                        in_cs_next    = 1'b0;
                        wants_next    = 1'b0;
                        pending_next  = '0;
                        clock_next    = ticked;
                        send_map_next = deferred_reg;
                        deferred_next = '0;
                    end
                end
                ramn_pkg::OP_TIMEOUT: begin
                    if (!failed_reg && wants_reg && !in_cs_reg) begin
                        wants_next    = 1'b0;
                        pending_next  = '0;
                        send_map_next = deferred_reg;
                        deferred_next = '0;
                    end
                end
                ramn_pkg::OP_FAIL_TOGGLE: begin
                    if (!failed_reg) begin
                        failed_next   = 1'b1;
                        pending_next  = '0;
                        wants_next    = 1'b0;
                        in_cs_next    = 1'b0;
                        send_map_next = deferred_reg;
                        deferred_next = '0;
                    end else begin
                        failed_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.emit_msg) begin
            send_map_next = send_map_reg & ~sel_hot;
        end
        if (cmd.advance) begin
            idx_next = idx_reg + IW'(1);
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign load_out = cmd.emit_msg || cmd.emit_none;

    assign dp_status.send_empty = (send_map_reg == '0);
    assign dp_status.cur_bit    = |(send_map_reg & sel_hot);
    assign dp_status.rest_empty = ((send_map_reg & ~sel_hot) == '0);
    assign dp_status.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg    <= PW'(1);
            clock_reg     <= '0;
            own_stamp_reg <= '0;
            pending_reg   <= '0;
            wants_reg     <= 1'b0;
            in_cs_reg     <= 1'b0;
            failed_reg    <= 1'b0;
            deferred_reg  <= '0;
            send_map_reg  <= '0;
            kind_reg      <= ramn_pkg::KIND_NONE;
            grant_reg     <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && (cfg_data != '0) && (int'(cfg_data) <= N)) begin
                own_id_reg <= cfg_data;
            end
            clock_reg     <= clock_next;
            own_stamp_reg <= own_stamp_next;
            pending_reg   <= pending_next;
            wants_reg     <= wants_next;
            in_cs_reg     <= in_cs_next;
            failed_reg    <= failed_next;
            deferred_reg  <= deferred_next;
            send_map_reg  <= send_map_next;
            kind_reg      <= kind_next;
            grant_reg     <= grant_next;
            idx_reg       <= idx_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg    <= ramn_pkg::op_t'(s_operation);
            snd_reg   <= s_sender_peer;
            stamp_reg <= s_in_stamp;
        end
        if (load_out) begin
            m_status_reg <= status_now;
            m_grant_reg  <= grant_reg;
            if (cmd.emit_msg) begin
                m_kind_reg  <= kind_reg;
                m_dest_reg  <= PW'(idx_reg) + PW'(1);
                m_stamp_reg <= clock_reg;
                m_last_reg  <= dp_status.rest_empty;
            end else begin
                m_kind_reg  <= ramn_pkg::KIND_NONE;
                m_dest_reg  <= '0;
                m_stamp_reg <= '0;
                m_last_reg  <= 1'b1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_msg_kind    = m_kind_reg;
    assign m_dest_peer   = m_dest_reg;
    assign m_out_stamp   = m_stamp_reg;
    assign m_node_status = m_status_reg;
    assign m_granted     = m_grant_reg;
    assign m_last_result = m_last_reg;

endmodule

`default_nettype wire

// ===== hdl/ricart_agrawala_mutex_node.sv =====
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node
// One node of distributed mutual exclusion with a saturating Lamport clock.
//
// Input channel (s_*): one event word per handshake: peer request, peer
// reply, local request, release, timeout or fail toggle, with the sender id
// and the stamp carried by the message.
// Result channel (m_*): one or more words per event, each a message to send
// (request or reply, destination, stamp) or a single empty word, with node
// status and grant flag; m_last_result marks the final word of the event.
// Config channel (cfg_*): writes own node id; ids outside 1..NODE_COUNT drop.
// Sequence: the event is latched on acceptance and evaluated in ST_EVAL;
// ST_SCAN then registers a message word for each peer in the map, lowest
// id first, or ST_NONE registers a lone empty word when the map is empty.
// Throughput: the sequencer walks the outgoing peer map one peer per cycle
// while the output register is free.
// Reset clears all node state, sets own id to 1, empties the output and
// holds both ready outputs low.
// When the receiver stalls, the walk holds at the pending peer until the
// output register frees; the next event is taken once the walk finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module ricart_agrawala_mutex_node (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [ramn_pkg::PEER_W-1:0]        cfg_data,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [ramn_pkg::OP_W-1:0]          s_operation,
    input  wire  [ramn_pkg::PEER_W-1:0]        s_sender_peer,
    input  wire  [ramn_pkg::STAMP_W-1:0]       s_in_stamp,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [ramn_pkg::KIND_W-1:0]        m_msg_kind,
    output logic [ramn_pkg::PEER_W-1:0]        m_dest_peer,
    output logic [ramn_pkg::STAMP_W-1:0]       m_out_stamp,
    output logic [ramn_pkg::STATUS_W-1:0]      m_node_status,
    output logic                               m_granted,
    output logic                               m_last_result
);

    ramn_pkg::ctrl_cmd_t  cmd;
    ramn_pkg::dp_status_t dp_status;

    ramn_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    ramn_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_operation   (s_operation),
        .s_sender_peer (s_sender_peer),
        .s_in_stamp    (s_in_stamp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_msg_kind    (m_msg_kind),
        .m_dest_peer   (m_dest_peer),
        .m_out_stamp   (m_out_stamp),
        .m_node_status (m_node_status),
        .m_granted     (m_granted),
        .m_last_result (m_last_result),
        .cmd           (cmd),
        .dp_status     (dp_status)
    );

endmodule

`default_nettype wire

// ===== hdl/ramn_checker.sv =====
// ----------------------------------------------------------------------------
// ramn_checker
// Port-level checks on the mutual exclusion node, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ramn_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_valid,
    input wire                                s_ready,
    input wire                                m_valid,
    input wire                                m_ready,
    input wire [ramn_pkg::KIND_W-1:0]         m_msg_kind,
    input wire [ramn_pkg::PEER_W-1:0]         m_dest_peer,
    input wire [ramn_pkg::STAMP_W-1:0]        m_out_stamp,
    input wire [ramn_pkg::STATUS_W-1:0]       m_node_status,
    input wire                                m_granted,
    input wire                                m_last_result
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before event evaluated");

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_msg_kind == ramn_pkg::KIND_NONE) |->
            (m_dest_peer == '0) && (m_out_stamp == '0) && m_last_result)
        else $error("empty word carries message fields or is not last");

    a_no_grant_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_node_status == ramn_pkg::STATUS_FAILED) |-> !m_granted)
        else $error("grant reported by a failed node");

    a_grant_in_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> (m_node_status == ramn_pkg::STATUS_IN_CS))
        else $error("grant without entering critical section");

endmodule

bind ricart_agrawala_mutex_node ramn_checker u_ramn_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_msg_kind    (m_msg_kind),
    .m_dest_peer   (m_dest_peer),
    .m_out_stamp   (m_out_stamp),
    .m_node_status (m_node_status),
    .m_granted     (m_granted),
    .m_last_result (m_last_result)
);

`default_nettype wire
